// ----- design/telemetry_frame_encoder_macros.svh -----
// assertion macros shared by the telemetry frame encoder modules
// expects clk_i and rst_ni in the scope of each use
`ifndef TELEMETRY_FRAME_ENCODER_MACROS_SVH
`define TELEMETRY_FRAME_ENCODER_MACROS_SVH

// property checked on every clock edge outside reset
`define TFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define TFE_ASSERT_NEVER(lbl, cond, msg) \
  `TFE_ASSERT(lbl, !(cond), msg)

`endif

// ----- design/tfe_pkg.sv -----
// shared types and constants of the telemetry frame encoder
// no dependencies; used by tfe_front, tfe_fifo, tfe_back and the top level
package tfe_pkg;

  localparam int ByteW = 8;
  localparam int ValW  = 16;
  localparam int NumVals = 4;
  localparam int IdxW  = 4;

  // frame constants
  localparam logic [ByteW-1:0] FrameHead  = 8'hAA;
  localparam logic [ByteW-1:0] FrameIdOne = 8'hF1;
  localparam logic [ByteW-1:0] FrameIdTwo = 8'hF2;
  localparam logic [ByteW-1:0] AddrReset  = 8'hFF;
  localparam logic [ByteW-1:0] LenOne     = 8'd4;
  localparam logic [ByteW-1:0] LenTwo     = 8'd8;

  // command codes
  localparam logic CmdOnePair = 1'b0;
  localparam logic CmdTwoPair = 1'b1;

  // byte positions inside a frame
  localparam logic [IdxW-1:0] IdxHead    = 4'd0;
  localparam logic [IdxW-1:0] IdxAddr    = 4'd1;
  localparam logic [IdxW-1:0] IdxId      = 4'd2;
  localparam logic [IdxW-1:0] IdxLen     = 4'd3;
  localparam logic [IdxW-1:0] IdxPayload = 4'd4;
  localparam logic [IdxW-1:0] LastIdxOne = 4'd9;
  localparam logic [IdxW-1:0] LastIdxTwo = 4'd13;

  // request queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // classified request as the back end needs it
  typedef struct packed {
    logic [ByteW-1:0]              dest;
    logic [ByteW-1:0]              func_id;
    logic [ByteW-1:0]              len;
    logic [IdxW-1:0]               last_idx;
    logic [NumVals-1:0][ValW-1:0]  vals;
  } desc_t;

endpackage

// ----- design/telemetry_frame_encoder.sv -----
// top level of the telemetry frame encoder: front, request queue, back
// depends on tfe_pkg, tfe_front, tfe_fifo and tfe_back
//
// usage
//   cfg channel (cfg_valid_i/cfg_ready_o, dest_address_i) writes the
//   destination address byte; cfg_ready_o is always high; reset value 0xFF
//   in channel (in_valid_i/in_ready_o) takes one telemetry request:
//   command_i picks one pair (10-byte frame) or two pairs (14-byte frame)
//   out channel (out_valid_o/out_ready_i) gives the frame one byte per
//   transfer, last_byte_o high on the add-check byte closing the frame
//   a request is first written into the queue; with the queue and output empty,
//   its first byte is then loaded into the output register
//   one byte per cycle while the receiver does not stall, set by the single
//   byte serializer in the back end; queued frames follow with no gap
//   a two-entry request queue lets the input take new requests while the
//   back end is still sending an earlier frame
//   receiver stall: the output register holds its byte, the serializer
//   waits, the queue fills and in_ready_o then drops
//   reset: queue empty, no byte pending, address back to 0xFF
module telemetry_frame_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         dest_address_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic signed [15:0] target_first_i,
  input  logic signed [15:0] measure_first_i,
  input  logic signed [15:0] target_second_i,
  input  logic signed [15:0] measure_second_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               last_byte_o
);

  // request handoff from front to queue
  logic           push, q_full;
  tfe_pkg::desc_t push_desc;

  // queue head seen by the back end
  logic           head_valid, pop;
  tfe_pkg::desc_t head_desc;

  tfe_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .dest_address_i   (dest_address_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .target_first_i   (target_first_i),
    .measure_first_i  (measure_first_i),
    .target_second_i  (target_second_i),
    .measure_second_i (measure_second_i),
    .push_o           (push),
    .q_full_i         (q_full),
    .desc_o           (push_desc)
  );

  // decouples request intake from byte serialization
  tfe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .desc_i       (push_desc),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_desc)
  );

  // serializer and output register
  tfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_desc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

// ----- design/tfe_front.sv -----
// front end: address register, request acceptance and classification
// depends on tfe_pkg
module tfe_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [7:0]               dest_address_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     command_i,
  input  logic signed [15:0]       target_first_i,
  input  logic signed [15:0]       measure_first_i,
  input  logic signed [15:0]       target_second_i,
  input  logic signed [15:0]       measure_second_i,
  output logic                     push_o,
  input  logic                     q_full_i,
  output tfe_pkg::desc_t           desc_o
);

  logic [tfe_pkg::ByteW-1:0] dest_q, dest_d;

  assign cfg_ready_o = 1'b1;
  assign dest_d      = (cfg_valid_i) ? dest_address_i : dest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q <= tfe_pkg::AddrReset;
    end else begin
      dest_q <= dest_d;
    end
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    desc_o.dest    = dest_q;
    desc_o.vals[0] = target_first_i;
    desc_o.vals[1] = measure_first_i;
    desc_o.vals[2] = target_second_i;
    desc_o.vals[3] = measure_second_i;
    unique case (command_i)
      tfe_pkg::CmdTwoPair: begin
        desc_o.func_id  = tfe_pkg::FrameIdTwo;
        desc_o.len      = tfe_pkg::LenTwo;
        desc_o.last_idx = tfe_pkg::LastIdxTwo;
      end
      default: begin
        desc_o.func_id  = tfe_pkg::FrameIdOne;
        desc_o.len      = tfe_pkg::LenOne;
        desc_o.last_idx = tfe_pkg::LastIdxOne;
      end
    endcase
  end

endmodule

// ----- design/tfe_fifo.sv -----
// short request queue between front and back end
// depends on tfe_pkg
module tfe_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tfe_pkg::desc_t  desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output tfe_pkg::desc_t  head_o
);

  tfe_pkg::desc_t                 mem_q [tfe_pkg::QDepth];
  logic [tfe_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tfe_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o       = (cnt_q == tfe_pkg::QCntW'(tfe_pkg::QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == tfe_pkg::QPtrW'(tfe_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == tfe_pkg::QPtrW'(tfe_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

// ----- design/tfe_back.sv -----
// back end: walks a queued request byte by byte, keeps the two checks,
// and holds the output register; depends on tfe_pkg and the macro header
`include "telemetry_frame_encoder_macros.svh"

module tfe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  tfe_pkg::desc_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_byte_o
);

  logic [tfe_pkg::IdxW-1:0]  idx_q, idx_d, pay_idx;
  logic [tfe_pkg::ByteW-1:0] sum_q, sum_d, acc_q, acc_d;
  logic [tfe_pkg::ByteW-1:0] byte_q, byte_d, sel_byte, sum_next;
  logic [tfe_pkg::ValW-1:0]  sel_word;
  logic                      valid_q, valid_d, last_q, last_d;
  logic                      load, fire, is_last, is_sum;

  assign load    = !valid_q || out_ready_i;
  assign fire    = head_valid_i && load;
  assign is_last = (idx_q == head_i.last_idx);
  assign is_sum  = (idx_q == (head_i.last_idx - 4'd1));
  assign pop_o   = fire && is_last;

  assign pay_idx  = idx_q - tfe_pkg::IdxPayload;
  assign sel_word = head_i.vals[pay_idx[2:1]];
  assign sum_next = sum_q + sel_byte;

  // byte picked for the current position
  always_comb begin
    unique case (idx_q)
      tfe_pkg::IdxHead: sel_byte = tfe_pkg::FrameHead;
      tfe_pkg::IdxAddr: sel_byte = head_i.dest;
      tfe_pkg::IdxId:   sel_byte = head_i.func_id;
      tfe_pkg::IdxLen:  sel_byte = head_i.len;
      default: begin
        if (is_last) begin
          sel_byte = acc_q;
        end else if (is_sum) begin
          sel_byte = sum_q;
        end else begin
          sel_byte = pay_idx[0] ? sel_word[15:8] : sel_word[7:0];
        end
      end
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    sum_d   = sum_q;
    acc_d   = acc_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (fire) begin
      valid_d = 1'b1;
      byte_d  = sel_byte;
      last_d  = is_last;
      if (is_last) begin
        idx_d = '0;
        sum_d = '0;
        acc_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
        if (!is_sum) begin
          sum_d = sum_next;
          acc_d = acc_q + sum_next;
        end
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      sum_q   <= '0;
      acc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      acc_q   <= acc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign last_byte_o = last_q;

  `TFE_ASSERT_NEVER(a_idle_idx, !head_valid_i && (idx_q != '0), "byte index off zero with no request")
  `TFE_ASSERT(a_idx_range, head_valid_i |-> (idx_q <= head_i.last_idx), "byte index past frame end")
  `TFE_ASSERT(a_check_clear, (idx_q == '0) |-> ((sum_q == '0) && (acc_q == '0)), "checks not cleared at frame start")
  `TFE_ASSERT(a_last_wraps, (fire && is_last) |=> (idx_q == '0), "frame end did not restart index")

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for telemetry_frame_encoder: drives telemetry requests,
// predicts every frame byte and checks the byte stream with random idling on both sides
// depends on tfe_pkg and the telemetry_frame_encoder rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // run sizing
  localparam int RandomItems   = 150;
  localparam int ChunkItems    = 25;
  localparam int DrainCycles   = 8;
  localparam int WatchdogLimit = 1000;

  // one expected byte of a frame
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // dut signals; the inputs are known from time zero
  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               cfg_valid_i      = 1'b0;
  logic               cfg_ready_o;
  logic [7:0]         dest_address_i   = 8'h00;
  logic               in_valid_i       = 1'b0;
  logic               in_ready_o;
  logic               command_i        = tfe_pkg::CmdOnePair;
  logic signed [15:0] target_first_i   = '0;
  logic signed [15:0] measure_first_i  = '0;
  logic signed [15:0] target_second_i  = '0;
  logic signed [15:0] measure_second_i = '0;
  logic               out_valid_o;
  logic               out_ready_i      = 1'b1;
  logic [7:0]         out_byte_o;
  logic               last_byte_o;

  // predictor state: the address register as the dut should hold it
  logic [7:0]  dest_addr_shadow = tfe_pkg::AddrReset;
  // frame bytes still owed by the dut, oldest first
  frame_byte_t expected_bytes[$];
  int          error_count = 0;

  // idling knobs, changed per test phase
  bit sender_idle_en = 1'b0;
  bit recv_stall_en  = 1'b0;
  int stall_left     = 0;

  telemetry_frame_encoder uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .dest_address_i   (dest_address_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .target_first_i   (target_first_i),
    .measure_first_i  (measure_first_i),
    .target_second_i  (target_second_i),
    .measure_second_i (measure_second_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .last_byte_o      (last_byte_o)
  );

  // 4 ns clock
  always #2 clk_i = ~clk_i;

  // gap length: mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // payload value biased toward the signed extremes and all-ones/all-zeros
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // builds the frame for one request and queues its bytes as expected results
  function automatic void encode_frame(input logic cmd,
                                       input logic signed [15:0] tgt1, msr1, tgt2, msr2);
    logic [7:0]  frame[$];
    logic [7:0]  sum;
    logic [7:0]  acc;
    frame_byte_t fb;
    sum = '0;
    acc = '0;
    frame.push_back(tfe_pkg::FrameHead);
    frame.push_back(dest_addr_shadow);
    frame.push_back((cmd == tfe_pkg::CmdTwoPair) ? tfe_pkg::FrameIdTwo : tfe_pkg::FrameIdOne);
    frame.push_back((cmd == tfe_pkg::CmdTwoPair) ? tfe_pkg::LenTwo : tfe_pkg::LenOne);
    // values go out low byte first, as raw two's complement
    frame.push_back(tgt1[7:0]);
    frame.push_back(tgt1[15:8]);
    frame.push_back(msr1[7:0]);
    frame.push_back(msr1[15:8]);
    // second pair only exists in two-pair frames
    if (cmd == tfe_pkg::CmdTwoPair) begin
      frame.push_back(tgt2[7:0]);
      frame.push_back(tgt2[15:8]);
      frame.push_back(msr2[7:0]);
      frame.push_back(msr2[15:8]);
    end
    // sum check is the wrapping byte sum, add check sums the running sums
    foreach (frame[i]) begin
      sum = sum + frame[i];
      acc = acc + sum;
    end
    frame.push_back(sum);
    frame.push_back(acc);
    foreach (frame[i]) begin
      fb.data = frame[i];
      fb.last = (i == frame.size() - 1);
      expected_bytes.push_back(fb);
    end
  endfunction

  // sends one request; valid stays high after acceptance so a zero gap streams requests
  task automatic send_request(input logic cmd,
                              input logic signed [15:0] tgt1, msr1, tgt2, msr2);
    int gap;
    gap = sender_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    target_first_i   <= tgt1;
    measure_first_i  <= msr1;
    target_second_i  <= tgt2;
    measure_second_i <= msr2;
    // signals read right after the edge still hold their pre-edge values
    do @(posedge clk_i); while (!in_ready_o);
    encode_frame(cmd, tgt1, msr1, tgt2, msr2);
  endtask

  // stop sending and wait until every owed byte has come out, then let the pipe settle
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // address write, only with the block idle
  task automatic write_dest_address(input logic [7:0] addr);
    wait_for_drain();
    cfg_valid_i    <= 1'b1;
    dest_address_i <= addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dest_addr_shadow = addr;
  endtask

  // receiver side: random stalls, long ones now and then, or none at all
  always @(posedge clk_i) begin : drive_out_ready
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (recv_stall_en && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= pick_gap();
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compares every accepted byte with the oldest expected one
  always @(posedge clk_i) begin : check_frame_bytes
    frame_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: no byte expected, got %02h (last_byte %0b)", out_byte_o, last_byte_o);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.data) begin
          $error("out_byte mismatch: expected %02h, actual %02h", want.data, out_byte_o);
          error_count++;
        end
        if (last_byte_o !== want.last) begin
          $error("last_byte mismatch: expected %0b, actual %0b", want.last, last_byte_o);
          error_count++;
        end
      end
    end
  end

  // watchdog: ends the run when no channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $error("watchdog: no request moved for %0d cycles", WatchdogLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  // address register must come out of reset as 0xFF
  task automatic test_reset_address();
    sender_idle_en = 1'b0;
    recv_stall_en  = 1'b0;
    send_request(tfe_pkg::CmdOnePair, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_request(tfe_pkg::CmdTwoPair, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
  endtask

  // signed extremes and alternating bit patterns in every value field
  task automatic test_field_extremes();
    sender_idle_en = 1'b0;
    recv_stall_en  = 1'b1;
    send_request(tfe_pkg::CmdTwoPair, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_request(tfe_pkg::CmdTwoPair, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_request(tfe_pkg::CmdTwoPair, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
    send_request(tfe_pkg::CmdTwoPair, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
    send_request(tfe_pkg::CmdOnePair, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000);
    send_request(tfe_pkg::CmdOnePair, 16'shFFFF, 16'sh0000, 16'shFFFF, 16'shFFFF);
  endtask

  // one-pair frames must ignore whatever sits on the second pair
  task automatic test_unused_pair();
    sender_idle_en = 1'b1;
    recv_stall_en  = 1'b1;
    send_request(tfe_pkg::CmdOnePair, 16'sh1234, 16'shEDCB, 16'sh7FFF, 16'sh8000);
    send_request(tfe_pkg::CmdOnePair, 16'sh0001, 16'shFFFE, 16'shFFFF, 16'shFFFF);
  endtask

  // address register at both ends and a pattern in between
  task automatic test_dest_address();
    sender_idle_en = 1'b1;
    recv_stall_en  = 1'b1;
    write_dest_address(8'h00);
    send_request(tfe_pkg::CmdOnePair, 16'sh0102, 16'sh0304, 16'sh0000, 16'sh0000);
    send_request(tfe_pkg::CmdTwoPair, 16'sh0102, 16'sh0304, 16'sh0506, 16'sh0708);
    write_dest_address(8'h5A);
    send_request(tfe_pkg::CmdTwoPair, 16'shFF00, 16'sh00FF, 16'shF00F, 16'sh0FF0);
    write_dest_address(8'hFF);
    send_request(tfe_pkg::CmdOnePair, 16'sh7F80, 16'sh807F, 16'sh0000, 16'sh0000);
  endtask

  // random requests in phases; each phase may change the address and the idling mix
  task automatic test_random_traffic();
    int sent;
    int chunk;
    logic cmd;
    sent  = 0;
    chunk = 0;
    while (sent < RandomItems) begin
      case (chunk % 4)
        0: write_dest_address(chunk == 0 ? 8'h00 : 8'($urandom));
        1: write_dest_address(chunk == 1 ? 8'hFF : 8'($urandom));
        default: wait_for_drain();
      endcase
      // one phase runs flat out on both sides, the others idle at random, chunk 3 always with receiver stalls
      if (chunk == 2) begin
        sender_idle_en = 1'b0;
        recv_stall_en  = 1'b0;
      end else begin
        sender_idle_en = 1'($urandom_range(0, 1));
        recv_stall_en  = (chunk == 3) ? 1'b1 : 1'($urandom_range(0, 1));
      end
      for (int i = 0; i < ChunkItems && sent < RandomItems; i++) begin
        // now and then hold off until the whole backlog has drained
        if ($urandom_range(0, 29) == 0) wait_for_drain();
        cmd = 1'($urandom_range(0, 1));
        send_request(cmd, pick_value(), pick_value(), pick_value(), pick_value());
        sent++;
      end
      chunk++;
    end
  endtask

  initial begin : main
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_address();
    test_field_extremes();
    test_unused_pair();
    test_dest_address();
    test_random_traffic();

    wait_for_drain();
    if (expected_bytes.size() != 0) begin
      $error("frame bytes missing: %0d still expected", expected_bytes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
